@@ rtl/core/csc_pkg.sv @@
// Shared constants and types for the calibrated color scaler.
// Used by csc_lane, the top level and the port checker.

package csc_pkg;

  // Sample width default for the top-level parameter
  localparam int unsigned ADC_BITS_DEF = 12;

  // Calibration dump layout
  localparam int unsigned DUMP_LEN   = 54;
  localparam int unsigned GAIN_BYTES = 48;
  localparam int unsigned THRESH_END = 52;
  localparam int unsigned NUM_COLORS = 3;
  localparam int unsigned NUM_ROWS   = 3;

  // Configuration register indexes and reset values
  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_FLOOR = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CEIL  = 1'd1;
  localparam logic [11:0] FLOOR_RST = 12'd50;
  localparam logic [11:0] CEIL_RST  = 12'd750;

  // Percent scaling
  localparam int unsigned PCT_W     = 7;
  localparam logic [PCT_W-1:0] PCT_MAX = 7'd100;
  localparam int unsigned DIV_STEPS = PCT_W;

  // Gain divide: the product is clamped at (PCT_MAX + 1) * GAIN_DIV, which
  // is enough to tell a saturated result, so the accumulator stays narrow.
  localparam int unsigned GAIN_DIV = 111410;
  localparam int unsigned ACC_W    = 24;
  localparam int unsigned DSH_W    = 23;
  localparam logic [ACC_W-1:0] SAT_CAP = ACC_W'(GAIN_DIV * 101);
  localparam logic [DSH_W-1:0] DIV_TOP = DSH_W'(GAIN_DIV * 64);

  // Per-step controls from the sequencer to each color lane
  typedef struct packed {
    logic start;  // latch a new sample difference
    logic mul;    // one shift-add step, sample MSB first
    logic div;    // one restoring divide step
  } lane_ctl_t;

endpackage

@@ rtl/core/csc_lane.sv @@
// One color lane: bit-serial multiply of (color - ambient) by its gain,
// then a restoring divide by the gain divisor, saturating at 100 percent.
// Depends on csc_pkg.

module csc_lane #(
  parameter int unsigned ADC_BITS = csc_pkg::ADC_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  csc_pkg::lane_ctl_t            ctl_i,
  input  logic [ADC_BITS-1:0]           color_i,
  input  logic [ADC_BITS-1:0]           amb_i,
  input  logic [31:0]                   gain_i,
  output logic [csc_pkg::PCT_W-1:0]     pct_o
);

  logic [ADC_BITS-1:0]          diff_q, diff_d;
  logic [csc_pkg::ACC_W-1:0]    acc_q, acc_d;
  logic [csc_pkg::DSH_W-1:0]    dsh_q, dsh_d;
  logic [csc_pkg::PCT_W-1:0]    quo_q, quo_d;
  logic [32:0]                  sum_w;
  logic                         fits_w;

  // Shift-add: accumulator doubles and takes the gain when the sample bit is set
  assign sum_w  = 33'({acc_q, 1'b0}) + 33'(diff_q[ADC_BITS-1] ? gain_i : 32'd0);
  assign fits_w = ({1'b0, acc_q} >= {2'b00, dsh_q});

  // Step control
  always_comb begin
    diff_d = diff_q;
    acc_d  = acc_q;
    dsh_d  = dsh_q;
    quo_d  = quo_q;
    if (ctl_i.start) begin
      diff_d = (color_i > amb_i) ? (color_i - amb_i) : '0;
      acc_d  = '0;
      dsh_d  = csc_pkg::DIV_TOP;
      quo_d  = '0;
    end else if (ctl_i.mul) begin
      diff_d = {diff_q[ADC_BITS-2:0], 1'b0};
      acc_d  = (sum_w >= 33'(csc_pkg::SAT_CAP)) ? csc_pkg::SAT_CAP
                                                : sum_w[csc_pkg::ACC_W-1:0];
    end else if (ctl_i.div) begin
      if (fits_w) begin
        acc_d = acc_q - csc_pkg::ACC_W'(dsh_q);
      end
      quo_d = {quo_q[csc_pkg::PCT_W-2:0], fits_w};
      dsh_d = {1'b0, dsh_q[csc_pkg::DSH_W-1:1]};
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      diff_q <= '0;
      acc_q  <= '0;
      dsh_q  <= '0;
      quo_q  <= '0;
    end else begin
      diff_q <= diff_d;
      acc_q  <= acc_d;
      dsh_q  <= dsh_d;
      quo_q  <= quo_d;
    end
  end

  // A clamped product divides to 101; report it as full scale
  assign pct_o = (quo_q > csc_pkg::PCT_MAX) ? csc_pkg::PCT_MAX : quo_q;

endmodule

@@ rtl/core/color_sensor_calibrated_scaler_top.sv @@
// Calibrated color scaler, top level: calibration store, sequencer,
// ambient divider and three color lanes. Depends on csc_pkg and csc_lane.

// A load item (command 0) stores the next byte of the 54-byte calibration
// dump; it gives no result. A measure item (command 1) gives one result and
// keeps the input stalled after its transfer until that result is loaded
// into the output register, so a new measure is taken only once the last
// one is through: the three color lanes multiply by shift-add, one sample
// bit per cycle, then run a 7-step restoring divide next to the ambient
// divider, and the result then moves into the output register. The stall
// lasts longer while an earlier result still waits in the output register.
// The output register frees the input side, so load items are taken while
// a result waits. The configuration registers should be written only while
// no measure is in progress.

module color_sensor_calibrated_scaler_top #(
  parameter int unsigned ADC_BITS = csc_pkg::ADC_BITS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // configuration write port
  input  logic                              cfg_we_i,
  input  logic [csc_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [11:0]                       cfg_wdata_i,
  // input channel
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic                              command_i,
  input  logic [7:0]                        cal_byte_i,
  input  logic [ADC_BITS-1:0]               red_raw_i,
  input  logic [ADC_BITS-1:0]               green_raw_i,
  input  logic [ADC_BITS-1:0]               blue_raw_i,
  input  logic [ADC_BITS-1:0]               ambient_raw_i,
  // output channel
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [csc_pkg::PCT_W-1:0]         red_pct_o,
  output logic [csc_pkg::PCT_W-1:0]         green_pct_o,
  output logic [csc_pkg::PCT_W-1:0]         blue_pct_o,
  output logic [csc_pkg::PCT_W-1:0]         ambient_pct_o
);

  localparam int unsigned CntW = $clog2(ADC_BITS);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_MUL  = 2'd1;
  localparam logic [1:0] ST_DIV  = 2'd2;
  localparam logic [1:0] ST_DONE = 2'd3;

  logic [1:0]        state_q, state_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic              in_xfer_w, meas_w, load_w, out_xfer_w, out_load_w;

  logic [11:0]       floor_q, ceil_q;
  logic [5:0]        pos_q;
  logic [31:0]       gain_q [csc_pkg::NUM_COLORS][csc_pkg::NUM_ROWS];
  logic [15:0]       thr_q [2];
  logic [1:0]        row_q;

  logic [18:0]       arem_q, arem_d;
  logic [17:0]       adsh_q, adsh_d;
  logic [csc_pkg::PCT_W-1:0] aquo_q, aquo_d;
  logic              azero_q, azero_d;
  logic [15:0]       amb16_w;
  logic [11:0]       aclip_w, aclamp_w, aoff_w;
  logic              afits_w;

  logic              out_valid_q;
  logic [csc_pkg::PCT_W-1:0] red_q, green_q, blue_q, amb_pct_q;

  csc_pkg::lane_ctl_t        lane_ctl;
  logic [ADC_BITS-1:0]       color_w [csc_pkg::NUM_COLORS];
  logic [31:0]               gain_w  [csc_pkg::NUM_COLORS];
  logic [csc_pkg::PCT_W-1:0] pct_w   [csc_pkg::NUM_COLORS];

  // Handshake
  assign in_stall_o = (state_q != ST_IDLE);
  assign in_xfer_w  = in_valid_i & ~in_stall_o;
  assign meas_w     = in_xfer_w & command_i;
  assign load_w     = in_xfer_w & ~command_i;
  assign out_xfer_w = out_valid_q & ~out_stall_i;
  assign out_load_w = (state_q == ST_DONE) & (~out_valid_q | ~out_stall_i);

  // Sequencer
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    case (state_q)
      ST_IDLE: begin
        if (meas_w) begin
          state_d = ST_MUL;
          cnt_d   = CntW'(ADC_BITS - 1);
        end
      end
      ST_MUL: begin
        if (cnt_q == '0) begin
          state_d = ST_DIV;
          cnt_d   = CntW'(csc_pkg::DIV_STEPS - 1);
        end else begin
          cnt_d = cnt_q - 1'b1;
        end
      end
      ST_DIV: begin
        if (cnt_q == '0) begin
          state_d = ST_DONE;
        end else begin
          cnt_d = cnt_q - 1'b1;
        end
      end
      ST_DONE: begin
        if (out_load_w) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      floor_q <= csc_pkg::FLOOR_RST;
      ceil_q  <= csc_pkg::CEIL_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        csc_pkg::CFG_FLOOR: floor_q <= cfg_wdata_i;
        csc_pkg::CFG_CEIL:  ceil_q  <= cfg_wdata_i;
        default: begin
        end
      endcase
    end
  end

  // Calibration dump: gains by byte, then thresholds, the last two bytes skipped.
  // The fourth gain of each row is never used and is not stored.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
      for (int c = 0; c < csc_pkg::NUM_COLORS; c++) begin
        for (int r = 0; r < csc_pkg::NUM_ROWS; r++) begin
          gain_q[c][r] <= '0;
        end
      end
      thr_q[0] <= '0;
      thr_q[1] <= '0;
    end else if (load_w) begin
      if (pos_q < 6'(csc_pkg::GAIN_BYTES)) begin
        if (pos_q[3:2] != 2'd3) begin
          gain_q[pos_q[3:2]][pos_q[5:4]][{pos_q[1:0], 3'b000} +: 8] <= cal_byte_i;
        end
      end else if (pos_q < 6'(csc_pkg::THRESH_END)) begin
        thr_q[pos_q[1]][{pos_q[0], 3'b000} +: 8] <= cal_byte_i;
      end
      pos_q <= (pos_q == 6'(csc_pkg::DUMP_LEN - 1)) ? '0 : pos_q + 1'b1;
    end
  end

  // Gain row from ambient against the dark thresholds
  assign amb16_w = 16'(ambient_raw_i);

  always_ff @(posedge clk_i) begin
    if (meas_w) begin
      if (amb16_w < thr_q[1]) begin
        row_q <= 2'd2;
      end else if (amb16_w < thr_q[0]) begin
        row_q <= 2'd1;
      end else begin
        row_q <= 2'd0;
      end
    end
  end

  // Color lanes
  assign color_w[0] = red_raw_i;
  assign color_w[1] = green_raw_i;
  assign color_w[2] = blue_raw_i;

  assign lane_ctl.start = meas_w;
  assign lane_ctl.mul   = (state_q == ST_MUL);
  assign lane_ctl.div   = (state_q == ST_DIV);

  for (genvar c = 0; c < csc_pkg::NUM_COLORS; c++) begin : g_lane
    assign gain_w[c] = gain_q[c][row_q];

    csc_lane #(
      .ADC_BITS (ADC_BITS)
    ) u_lane (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctl_i  (lane_ctl),
      .color_i(color_w[c]),
      .amb_i  (ambient_raw_i),
      .gain_i (gain_w[c]),
      .pct_o  (pct_w[c])
    );
  end

  // Ambient percent: clamp to floor..ceiling, then (a - floor) * 100 / span; zero if ceiling <= floor
  assign aclip_w  = (amb16_w > 16'(ceil_q)) ? ceil_q : amb16_w[11:0];
  assign aclamp_w = (aclip_w < floor_q) ? floor_q : aclip_w;
  assign aoff_w   = aclamp_w - floor_q;
  assign afits_w  = ({1'b0, adsh_q} <= arem_q);

  always_comb begin
    arem_d  = arem_q;
    adsh_d  = adsh_q;
    aquo_d  = aquo_q;
    azero_d = azero_q;
    if (meas_w) begin
      azero_d = (ceil_q <= floor_q);
      arem_d  = {1'b0, aoff_w, 6'b0} + {2'b0, aoff_w, 5'b0} + {5'b0, aoff_w, 2'b0};
      adsh_d  = {ceil_q - floor_q, 6'b0};
      aquo_d  = '0;
    end else if (state_q == ST_DIV) begin
      if (afits_w) begin
        arem_d = arem_q - {1'b0, adsh_q};
      end
      aquo_d = {aquo_q[csc_pkg::PCT_W-2:0], afits_w};
      adsh_d = {1'b0, adsh_q[17:1]};
    end
  end

  always_ff @(posedge clk_i) begin
    arem_q  <= arem_d;
    adsh_q  <= adsh_d;
    aquo_q  <= aquo_d;
    azero_q <= azero_d;
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load_w) begin
      out_valid_q <= 1'b1;
    end else if (out_xfer_w) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load_w) begin
      red_q     <= pct_w[0];
      green_q   <= pct_w[1];
      blue_q    <= pct_w[2];
      amb_pct_q <= azero_q ? '0 : aquo_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign red_pct_o     = red_q;
  assign green_pct_o   = green_q;
  assign blue_pct_o    = blue_q;
  assign ambient_pct_o = amb_pct_q;

endmodule

@@ rtl/core/csc_checker.sv @@
// Port-level checks for the calibrated color scaler, bound to the top level.
// Depends on csc_pkg.

module csc_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_stall_o,
  input logic                          command_i,
  input logic                          out_valid_o,
  input logic                          out_stall_i,
  input logic [csc_pkg::PCT_W-1:0]     red_pct_o,
  input logic [csc_pkg::PCT_W-1:0]     green_pct_o,
  input logic [csc_pkg::PCT_W-1:0]     blue_pct_o,
  input logic [csc_pkg::PCT_W-1:0]     ambient_pct_o
);

  // Every shown result is a percentage
  a_pct_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (red_pct_o <= csc_pkg::PCT_MAX) && (green_pct_o <= csc_pkg::PCT_MAX)
                 && (blue_pct_o <= csc_pkg::PCT_MAX) && (ambient_pct_o <= csc_pkg::PCT_MAX))
    else $error("result field above 100 percent");

  // A measure transfer holds the input side while it computes
  a_meas_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && command_i) |=> in_stall_o)
    else $error("input not stalled after a measure transfer");

  // A new result only appears at the end of a measure
  a_rose_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result appeared without a measure in progress");

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> out_valid_o && $stable(red_pct_o)
      && $stable(green_pct_o) && $stable(blue_pct_o) && $stable(ambient_pct_o))
    else $error("stalled result changed");

endmodule

bind color_sensor_calibrated_scaler_top csc_checker u_csc_checker (.*);

@@ tb/tb.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for color_sensor_calibrated_scaler_top: directed rows,
// then random calibration dumps and measures checked by a percent predictor.
// Depends on csc_pkg and the top level only.

module tb;

  // Command codes of the input item
  localparam logic CMD_LOAD    = 1'b0;
  localparam logic CMD_MEASURE = 1'b1;

  // Calibration dump layout and scaling, kept independent of the design
  localparam int unsigned     CAL_DUMP_BYTES = 54;
  localparam int unsigned     CAL_GAIN_BYTES = 48;
  localparam int unsigned     CAL_THRESH_END = 52;
  localparam longint unsigned GAIN_DIVISOR   = 111410;
  localparam int unsigned     PCT_FULL       = 100;
  localparam logic [11:0]     AMB_FLOOR_INIT = 12'd50;
  localparam logic [11:0]     AMB_CEIL_INIT  = 12'd750;

  // Run control
  localparam int unsigned DRAIN_CYCLES   = 40;
  localparam int unsigned CYCLE_LIMIT    = 500000;
  localparam int unsigned ITEMS_PER_PASS = 490;

  typedef logic [csc_pkg::PCT_W-1:0] pct_t;

  typedef struct packed {
    pct_t red;
    pct_t green;
    pct_t blue;
    pct_t ambient;
  } pct_set_t;

  typedef struct packed {
    logic        cmd;
    logic [7:0]  cal;
    logic [11:0] red;
    logic [11:0] green;
    logic [11:0] blue;
    logic [11:0] amb;
  } sensor_item_t;

  typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_e;

  typedef struct {
    row_kind_e                      kind;
    sensor_item_t                   item;
    bit                             typed;
    pct_set_t                       want;
    logic [csc_pkg::CFG_IDX_W-1:0]  idx;
    logic [11:0]                    data;
  } stim_row_t;

  // DUT signals
  logic                          clk = 1'b0;
  logic                          rst_n;
  logic                          cfg_we;
  logic [csc_pkg::CFG_IDX_W-1:0] cfg_idx;
  logic [11:0]                   cfg_wdata;
  logic                          in_valid;
  logic                          in_stall;
  logic                          command;
  logic [7:0]                    cal_byte;
  logic [11:0]                   red_raw, green_raw, blue_raw, ambient_raw;
  logic                          out_valid;
  logic                          out_stall = 1'b0;
  pct_t                          red_pct, green_pct, blue_pct, ambient_pct;

  // Predictor state: calibration store, dump position, ambient window
  logic [31:0]  gain_mem [12];
  logic [15:0]  dark_mem [2];
  int unsigned  cal_pos;
  logic [11:0]  amb_floor;
  logic [11:0]  amb_ceil;

  // Expected percent sets, oldest first
  pct_set_t     pct_q [$];

  // Scratch gains for building a dump
  logic [31:0]  gain_buf [12];

  stim_row_t    dir_rows [$];
  int unsigned  mismatch_cnt = 0;
  int unsigned  result_cnt = 0;
  int unsigned  cycle_cnt = 0;
  int unsigned  tx_idle_pct = 0;
  int unsigned  rx_idle_pct = 0;

  color_sensor_calibrated_scaler_top u_top (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .cfg_we_i      (cfg_we),
    .cfg_idx_i     (cfg_idx),
    .cfg_wdata_i   (cfg_wdata),
    .in_valid_i    (in_valid),
    .in_stall_o    (in_stall),
    .command_i     (command),
    .cal_byte_i    (cal_byte),
    .red_raw_i     (red_raw),
    .green_raw_i   (green_raw),
    .blue_raw_i    (blue_raw),
    .ambient_raw_i (ambient_raw),
    .out_valid_o   (out_valid),
    .out_stall_i   (out_stall),
    .red_pct_o     (red_pct),
    .green_pct_o   (green_pct),
    .blue_pct_o    (blue_pct),
    .ambient_pct_o (ambient_pct)
  );

  always #2 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // Color above ambient times gain over the divisor, saturated
  function automatic pct_t color_percent(logic [11:0] color, logic [11:0] amb,
                                         logic [31:0] gain);
    logic [63:0] diff;
    logic [63:0] quot;
    if (color < amb) return '0;
    diff = color - amb;
    quot = (diff * gain) / GAIN_DIVISOR;
    return (quot > PCT_FULL) ? pct_t'(PCT_FULL) : pct_t'(quot);
  endfunction

  // Ambient clamped into the window and scaled to percent
  function automatic pct_t ambient_percent(logic [11:0] amb);
    logic [11:0] a;
    logic [31:0] num;
    logic [31:0] span;
    if (amb_ceil <= amb_floor) return '0;
    a = amb;
    if (a > amb_ceil) a = amb_ceil;
    if (a < amb_floor) a = amb_floor;
    num  = (a - amb_floor) * PCT_FULL;
    span = amb_ceil - amb_floor;
    return pct_t'(num / span);
  endfunction

  function automatic pct_set_t predict_measure(sensor_item_t it);
    int unsigned row;
    pct_set_t    r;
    // darker ambient picks a higher gain row
    if (it.amb < dark_mem[1]) row = 2;
    else if (it.amb < dark_mem[0]) row = 1;
    else row = 0;
    r.red     = color_percent(it.red,   it.amb, gain_mem[row * 4]);
    r.green   = color_percent(it.green, it.amb, gain_mem[row * 4 + 1]);
    r.blue    = color_percent(it.blue,  it.amb, gain_mem[row * 4 + 2]);
    r.ambient = ambient_percent(it.amb);
    return r;
  endfunction

  // Little-endian gains, then two thresholds, then two check bytes
  function automatic void store_cal_byte(logic [7:0] b);
    if (cal_pos < CAL_GAIN_BYTES)
      gain_mem[cal_pos / 4][8 * (cal_pos % 4) +: 8] = b;
    else if (cal_pos < CAL_THRESH_END)
      dark_mem[(cal_pos - CAL_GAIN_BYTES) / 2][8 * ((cal_pos - CAL_GAIN_BYTES) % 2) +: 8] = b;
    cal_pos = (cal_pos + 1 >= CAL_DUMP_BYTES) ? 0 : cal_pos + 1;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic sensor_item_t random_item(logic cmd);
    sensor_item_t it;
    it.cmd   = cmd;
    it.cal   = 8'($urandom);
    it.red   = 12'($urandom);
    it.green = 12'($urandom);
    it.blue  = 12'($urandom);
    it.amb   = 12'($urandom);
    return it;
  endfunction

  // Small gains, larger ones, full 32-bit ones and some corner values
  function automatic logic [31:0] pick_gain();
    int unsigned sel;
    sel = $urandom_range(0, 99);
    if (sel < 40) return $urandom_range(0, 60000);
    if (sel < 60) return $urandom_range(0, 2000000);
    if (sel < 80) return $urandom;
    case ($urandom_range(0, 4))
      0: return 32'd0;
      1: return 32'd1;
      2: return 32'd111410;
      3: return 32'd11141000;
      default: return 32'hFFFF_FFFF;
    endcase
  endfunction

  // Colors mostly a little above ambient so the percent is not always 0 or 100
  function automatic logic [11:0] color_sample(logic [11:0] amb);
    int unsigned sel;
    int c;
    sel = $urandom_range(0, 99);
    if (sel < 55) c = int'(amb) + int'($urandom_range(0, 400));
    else if (sel < 70) c = int'(amb) - int'($urandom_range(0, 50));
    else c = int'($urandom_range(0, 4095));
    if (c < 0) c = 0;
    if (c > 4095) c = 4095;
    return 12'(c);
  endfunction

  function automatic sensor_item_t random_measure();
    sensor_item_t it;
    int a;
    it = random_item(CMD_MEASURE);
    // half the time hover around a dark threshold to hit the row edges
    if ($urandom_range(0, 1) == 1) begin
      a = int'(dark_mem[$urandom_range(0, 1)]) + int'($urandom_range(0, 8)) - 4;
      if (a < 0) a = 0;
      if (a > 4095) a = int'($urandom_range(0, 4095));
      it.amb = 12'(a);
    end
    it.red   = color_sample(it.amb);
    it.green = color_sample(it.amb);
    it.blue  = color_sample(it.amb);
    return it;
  endfunction

  // Byte p of a dump built from gain_buf and the two thresholds
  function automatic logic [7:0] dump_byte(int unsigned p, logic [15:0] th0,
                                           logic [15:0] th1);
    logic [15:0] th;
    if (p < CAL_GAIN_BYTES) return gain_buf[p / 4][8 * (p % 4) +: 8];
    if (p < CAL_THRESH_END) begin
      th = (p < CAL_GAIN_BYTES + 2) ? th0 : th1;
      return th[8 * ((p - CAL_GAIN_BYTES) % 2) +: 8];
    end
    return 8'($urandom);
  endfunction

  function automatic void add_load(logic [7:0] v);
    stim_row_t row;
    row.kind     = ROW_ITEM;
    row.item     = random_item(CMD_LOAD);
    row.item.cal = v;
    row.typed    = 1'b0;
    row.want     = '0;
    dir_rows.push_back(row);
  endfunction

  function automatic void add_measure(logic [11:0] r, logic [11:0] g, logic [11:0] b,
                                      logic [11:0] a);
    stim_row_t row;
    row.kind       = ROW_ITEM;
    row.item       = random_item(CMD_MEASURE);
    row.item.red   = r;
    row.item.green = g;
    row.item.blue  = b;
    row.item.amb   = a;
    row.typed      = 1'b0;
    row.want       = '0;
    dir_rows.push_back(row);
  endfunction

  // Measure whose result is written down by hand
  function automatic void add_typed(logic [11:0] r, logic [11:0] g, logic [11:0] b,
                                    logic [11:0] a, pct_set_t want);
    add_measure(r, g, b, a);
    dir_rows[$].typed = 1'b1;
    dir_rows[$].want  = want;
  endfunction

  function automatic void add_cfg(logic [csc_pkg::CFG_IDX_W-1:0] idx, logic [11:0] data);
    stim_row_t row;
    row.kind = ROW_CFG;
    row.item = '0;
    row.typed = 1'b0;
    row.want = '0;
    row.idx  = idx;
    row.data = data;
    dir_rows.push_back(row);
  endfunction

  // ---------------------------------------------------------------------------
  // Driving
  // ---------------------------------------------------------------------------

  // One input transfer, with an optional random gap in front of it
  task automatic drive_item(sensor_item_t it, bit typed, pct_set_t want);
    if ($urandom_range(0, 99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < tx_idle_pct);
    end
    in_valid    <= 1'b1;
    command     <= it.cmd;
    cal_byte    <= it.cal;
    red_raw     <= it.red;
    green_raw   <= it.green;
    blue_raw    <= it.blue;
    ambient_raw <= it.amb;
    do @(posedge clk); while (in_stall);
    // transfer taken at this edge
    if (it.cmd == CMD_LOAD) store_cal_byte(it.cal);
    else pct_q.push_back(typed ? want : predict_measure(it));
  endtask

  // Hold off until every expected result is back and the block is idle
  task automatic settle();
    in_valid <= 1'b0;
    do @(posedge clk); while (pct_q.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [csc_pkg::CFG_IDX_W-1:0] idx, logic [11:0] data);
    settle();
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == csc_pkg::CFG_FLOOR) amb_floor = data;
    else if (idx == csc_pkg::CFG_CEIL) amb_ceil = data;
  endtask

  task automatic load_random_dump();
    logic [15:0]  th_hi;
    logic [15:0]  th_lo;
    sensor_item_t it;
    for (int i = 0; i < 12; i++) gain_buf[i] = pick_gain();
    if ($urandom_range(0, 6) == 0) begin
      th_hi = 16'($urandom);
      th_lo = 16'($urandom);
    end else begin
      th_hi = 16'($urandom_range(0, 4095));
      th_lo = 16'($urandom_range(0, th_hi));
    end
    for (int p = 0; p < CAL_DUMP_BYTES; p++) begin
      it     = random_item(CMD_LOAD);
      it.cal = dump_byte(p, th_hi, th_lo);
      drive_item(it, 1'b0, '0);
    end
  endtask

  // Dumps, stray loads, measure bursts, pauses and window changes
  task automatic run_random_pass(int unsigned n_items);
    int unsigned sent;
    int unsigned pick;
    int unsigned burst;
    sent = 0;
    while (sent < n_items) begin
      pick = $urandom_range(0, 99);
      if (pick < 3) begin
        if ($urandom_range(0, 1) == 0) settle();
        else write_reg(($urandom_range(0, 1) == 0) ? csc_pkg::CFG_FLOOR
                                                   : csc_pkg::CFG_CEIL,
                       12'($urandom_range(0, 4095)));
      end else if (pick < 11) begin
        // usually finish a broken dump first so the new one lines up
        if (cal_pos != 0 && $urandom_range(0, 3) != 0) begin
          while (cal_pos != 0) begin
            drive_item(random_item(CMD_LOAD), 1'b0, '0);
            sent++;
          end
        end
        load_random_dump();
        sent += CAL_DUMP_BYTES;
      end else if (pick < 19) begin
        burst = $urandom_range(1, 4);
        repeat (burst) drive_item(random_item(CMD_LOAD), 1'b0, '0);
        sent += burst;
      end else begin
        burst = $urandom_range(4, 16);
        repeat (burst) drive_item(random_measure(), 1'b0, '0);
        sent += burst;
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------------

  task automatic report_mismatch(string msg);
    if (mismatch_cnt < 50) $display("[%0t] mismatch: %s", $time, msg);
    mismatch_cnt++;
  endtask

  // Result side stalls at random
  always @(posedge clk) begin
    out_stall <= ($urandom_range(0, 99) < rx_idle_pct);
  end

  // Compare each output transfer with the oldest expectation
  always @(posedge clk) begin : result_check
    pct_set_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pct_q.size() == 0) begin
        report_mismatch($sformatf("result %0d/%0d/%0d/%0d with nothing expected",
                                  red_pct, green_pct, blue_pct, ambient_pct));
      end else begin
        want = pct_q.pop_front();
        if (red_pct !== want.red)
          report_mismatch($sformatf("result %0d red_pct %0d, want %0d",
                                    result_cnt, red_pct, want.red));
        if (green_pct !== want.green)
          report_mismatch($sformatf("result %0d green_pct %0d, want %0d",
                                    result_cnt, green_pct, want.green));
        if (blue_pct !== want.blue)
          report_mismatch($sformatf("result %0d blue_pct %0d, want %0d",
                                    result_cnt, blue_pct, want.blue));
        if (ambient_pct !== want.ambient)
          report_mismatch($sformatf("result %0d ambient_pct %0d, want %0d",
                                    result_cnt, ambient_pct, want.ambient));
        result_cnt++;
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("FAIL color_sensor_calibrated_scaler_top");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------

  initial begin
    rst_n       = 1'b0;
    cfg_we      = 1'b0;
    cfg_idx     = csc_pkg::CFG_FLOOR;
    cfg_wdata   = '0;
    in_valid    = 1'b0;
    command     = CMD_LOAD;
    cal_byte    = '0;
    red_raw     = '0;
    green_raw   = '0;
    blue_raw    = '0;
    ambient_raw = '0;

    for (int i = 0; i < 12; i++) gain_mem[i] = '0;
    dark_mem[0] = '0;
    dark_mem[1] = '0;
    cal_pos     = 0;
    amb_floor   = AMB_FLOOR_INIT;
    amb_ceil    = AMB_CEIL_INIT;

    // Empty calibration: every gain is zero, default window 50..750
    add_typed(12'd4095, 12'd4095, 12'd4095, 12'd0,    '{7'd0, 7'd0, 7'd0, 7'd0});
    add_typed(12'd0,    12'd0,    12'd0,    12'd4095, '{7'd0, 7'd0, 7'd0, 7'd100});
    add_typed(12'd4095, 12'd0,    12'd4095, 12'd750,  '{7'd0, 7'd0, 7'd0, 7'd100});
    add_typed(12'd0,    12'd0,    12'd0,    12'd50,   '{7'd0, 7'd0, 7'd0, 7'd0});

    // Full dump with corner gains, thresholds 2000 and 1000
    gain_buf = '{32'hFFFF_FFFF, 32'd111410,  32'd1,          32'd0,
                 32'd11141000,  32'd222820,  32'h8000_0000,  32'hDEAD_BEEF,
                 32'd55705,     32'd1114100, 32'd0,          32'hFFFF_FFFF};
    for (int p = 0; p < CAL_DUMP_BYTES; p++) add_load(dump_byte(p, 16'd2000, 16'd1000));

    // Row edges, colors equal to and below ambient, saturation
    add_measure(12'd4095, 12'd3050, 12'd4095, 12'd3000);
    add_measure(12'd2000, 12'd1999, 12'd4095, 12'd2000);
    add_measure(12'd4095, 12'd2100, 12'd2001, 12'd1999);
    add_measure(12'd1500, 12'd1000, 12'd999,  12'd1000);
    add_measure(12'd1099, 12'd1000, 12'd4095, 12'd999);
    add_measure(12'd4095, 12'd4095, 12'd4095, 12'd0);

    // Loads past the end of the dump start a new one
    add_load(8'h34);
    add_load(8'h12);
    add_measure(12'd3100, 12'd3200, 12'd4000, 12'd3000);

    // Widest ambient window
    add_cfg(csc_pkg::CFG_FLOOR, 12'd0);
    add_cfg(csc_pkg::CFG_CEIL, 12'd4095);
    add_typed(12'd0, 12'd0, 12'd0, 12'd4095, '{7'd0, 7'd0, 7'd0, 7'd100});
    add_typed(12'd0, 12'd0, 12'd0, 12'd0,    '{7'd0, 7'd0, 7'd0, 7'd0});
    add_measure(12'd4095, 12'd4095, 12'd4095, 12'd2047);

    // Ceiling below floor, then equal to it: ambient reads zero
    add_cfg(csc_pkg::CFG_FLOOR, 12'd4095);
    add_cfg(csc_pkg::CFG_CEIL, 12'd0);
    add_typed(12'd0, 12'd0, 12'd0, 12'd2000, '{7'd0, 7'd0, 7'd0, 7'd0});
    add_cfg(csc_pkg::CFG_CEIL, 12'd4095);
    add_typed(12'd0, 12'd0, 12'd0, 12'd4095, '{7'd0, 7'd0, 7'd0, 7'd0});

    tx_idle_pct = 32;
    rx_idle_pct = 55;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_CFG) write_reg(dir_rows[i].idx, dir_rows[i].data);
      else drive_item(dir_rows[i].item, dir_rows[i].typed, dir_rows[i].want);
    end

    // Sender idles less than the receiver stalls
    write_reg(csc_pkg::CFG_FLOOR, 12'($urandom_range(0, 1500)));
    write_reg(csc_pkg::CFG_CEIL, 12'($urandom_range(amb_floor + 1, 4095)));
    run_random_pass(ITEMS_PER_PASS);

    // Roles swapped, window in any order
    tx_idle_pct = 55;
    rx_idle_pct = 32;
    write_reg(csc_pkg::CFG_FLOOR, 12'($urandom_range(0, 4095)));
    write_reg(csc_pkg::CFG_CEIL, 12'($urandom_range(0, 4095)));
    run_random_pass(ITEMS_PER_PASS);

    // Back to back, no idling
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    write_reg(csc_pkg::CFG_FLOOR, 12'($urandom_range(0, 2000)));
    write_reg(csc_pkg::CFG_CEIL, 12'($urandom_range(2000, 4095)));
    run_random_pass(ITEMS_PER_PASS);

    settle();
    if (mismatch_cnt == 0) $display("PASS color_sensor_calibrated_scaler_top");
    else $display("FAIL color_sensor_calibrated_scaler_top");
    $finish;
  end

endmodule

@@ color_sensor_calibrated_scaler_top.f @@
rtl/core/csc_pkg.sv
rtl/core/csc_lane.sv
rtl/core/color_sensor_calibrated_scaler_top.sv
rtl/core/csc_checker.sv
tb/tb.sv
